@@ hw/rtl/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// shared types and codes for the dual stack shared memory block
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_rd;
  } dss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;
  } dss_sts_t;

endpackage

@@ hw/rtl/dss_ram.sv @@
// ----------------------------------------------------------------------------
// dss_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
module dss_ram #(
  parameter int WIDTH = dss_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/dss_ctrl.sv @@
// ----------------------------------------------------------------------------
// dss_ctrl
// sequencer: accept a request, execute it, and for a pop or peek that finds data wait for ram read data
// ----------------------------------------------------------------------------
module dss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output dss_pkg::dss_cmd_t cmd,
  input  dss_pkg::dss_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_RDATA = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;
  logic       load_out;

  // result register is free or is being taken this cycle
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.load_rd = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.execute = 1'b1;
          if (sts.needs_read) begin
            state_nxt = S_RDATA;
          end else begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_RDATA: begin
        cmd.load_rd = 1'b1;
        load_out    = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/dss_dp.sv @@
// ----------------------------------------------------------------------------
// dss_dp
// stack heights, address generation, shared ram and result register
// ----------------------------------------------------------------------------
module dss_dp #(
  parameter int DEPTH      = dss_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dss_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dss_pkg::dss_cmd_t             cmd,
  output dss_pkg::dss_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [dss_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic [dss_pkg::CMD_W-1:0]     in_command,
  input  logic                          in_stack_select,
  input  logic signed [dss_pkg::VAL_W-1:0] in_push_value,
  output logic signed [dss_pkg::VAL_W-1:0] out_read_value,
  output logic [dss_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_first_empty,
  output logic                          out_second_empty,
  output logic                          out_memory_full
);

  localparam int HW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [dss_pkg::CMD_W-1:0]    cmd_r;
  logic                         sel_r;
  logic [dss_pkg::VAL_W-1:0]    val_r;
  logic [dss_pkg::SIZE_W-1:0]   size_r;
  logic [HW-1:0]                first_h_r, first_h_nxt;
  logic [HW-1:0]                second_h_r, second_h_nxt;

  logic signed [dss_pkg::VAL_W-1:0] read_value_r;
  logic [dss_pkg::STATUS_W-1:0] status_r, status_c;
  logic                         first_empty_r, second_empty_r, memory_full_r;

  logic [31:0]     size32;
  logic [HW-1:0]   eff_size;
  logic [HW:0]     total_c, total_nxt;
  logic            full_c;
  logic [HW-1:0]   sel_h;
  logic [HW-1:0]   addr_c;
  logic            write_ok, read_ok;
  logic [63:0]     val64, rd64;
  logic            ram_en, ram_we;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // register value held within two and the memory depth
  assign size32 = {21'b0, size_r};
  always_comb begin
    if (size32 < 32'd2) begin
      eff_size = HW'(2);
    end else if (size32 > 32'(DEPTH)) begin
      eff_size = HW'(DEPTH);
    end else begin
      eff_size = HW'(size32);
    end
  end

  assign total_c = {1'b0, first_h_r} + {1'b0, second_h_r};
  assign full_c  = total_c >= {1'b0, eff_size};
  assign sel_h   = sel_r ? second_h_r : first_h_r;

  always_comb begin
    status_c     = dss_pkg::ST_OK;
    write_ok     = 1'b0;
    read_ok      = 1'b0;
    addr_c       = '0;
    first_h_nxt  = first_h_r;
    second_h_nxt = second_h_r;
    case (cmd_r) inside
      dss_pkg::CMD_PUSH: begin
        if (full_c) begin
          status_c = dss_pkg::ST_FULL;
        end else begin
          write_ok = 1'b1;
          if (!sel_r) begin
            addr_c      = first_h_r;
            first_h_nxt = first_h_r + HW'(1);
          end else begin
            // stack two grows down from the top entry
            addr_c       = eff_size - HW'(1) - second_h_r;
            second_h_nxt = second_h_r + HW'(1);
          end
        end
      end
      dss_pkg::CMD_POP, dss_pkg::CMD_PEEK: begin
        if (sel_h == '0) begin
          status_c = dss_pkg::ST_EMPTY;
        end else begin
          read_ok = 1'b1;
          addr_c  = sel_r ? (eff_size - second_h_r) : (first_h_r - HW'(1));
          if (cmd_r == dss_pkg::CMD_POP) begin
            if (!sel_r) begin
              first_h_nxt = first_h_r - HW'(1);
            end else begin
              second_h_nxt = second_h_r - HW'(1);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign total_nxt = {1'b0, first_h_nxt} + {1'b0, second_h_nxt};

  assign sts.needs_read = read_ok;

  assign val64     = {32'b0, val_r};
  assign ram_wdata = val64[DATA_WIDTH-1:0];
  assign ram_en    = cmd.execute && (write_ok || read_ok);
  assign ram_we    = write_ok;
  assign rd64      = 64'(ram_rdata);

  dss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr_c[AW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      sel_r <= in_stack_select;
      val_r <= in_push_value;
    end
    if (cmd.execute) begin
      read_value_r   <= '0;
      status_r       <= status_c;
      first_empty_r  <= (first_h_nxt == '0);
      second_empty_r <= (second_h_nxt == '0);
      memory_full_r  <= (total_nxt >= {1'b0, eff_size});
    end
    if (cmd.load_rd) begin
      read_value_r <= rd64[dss_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= dss_pkg::SIZE_RESET;
      first_h_r  <= '0;
      second_h_r <= '0;
    end else if (cfg_we) begin
      // a new size empties both stacks
      size_r     <= cfg_wdata;
      first_h_r  <= '0;
      second_h_r <= '0;
    end else if (cmd.execute) begin
      first_h_r  <= first_h_nxt;
      second_h_r <= second_h_nxt;
    end
  end

  assign out_read_value   = read_value_r;
  assign out_status       = status_r;
  assign out_first_empty  = first_empty_r;
  assign out_second_empty = second_empty_r;
  assign out_memory_full  = memory_full_r;

  a_heights_fit: assert property (@(posedge clk) disable iff (!rst_n)
    total_c <= {1'b0, eff_size})
    else $error("stack heights exceed the shared size");

  a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && status_c != dss_pkg::ST_OK && !cfg_we)
      |=> ($stable(first_h_r) && $stable(second_h_r)))
    else $error("refused request changed a stack height");

  a_rd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rd |-> $past(ram_en && !ram_we))
    else $error("read data taken without a ram read");

  a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en |-> ({1'b0, addr_c} < {1'b0, eff_size}))
    else $error("ram address beyond the shared size");

endmodule

@@ hw/rtl/dual_stack_shared_memory.sv @@
// ----------------------------------------------------------------------------
// dual_stack_shared_memory
// two lifo stacks growing toward each other in one shared ram
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall carries one request: command (push, pop,
// peek), stack select and push value. output channel out_valid/out_stall
// returns one result per request: read value, status and the empty and full
// flags as they stand after the request.
// a request is taken when in_valid is high and in_stall is low. a push or a
// refused request is loaded into the result register from the execute state;
// a pop or peek that finds data goes on to the read-data state, for the
// registered read of the single ram port. the block works on one request at
// a time and takes none until the last is done; in_stall is low only while
// the sequencer is idle. the result sits in an output register, so the next
// request is taken while a result waits; a stalled receiver only holds back
// the execute step. cfg_we/cfg_wdata sets the shared size and empties both
// stacks; write it only while no request is in flight.
// after reset both stacks are empty, the size is 1024 and no result is valid.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory #(
  parameter int DEPTH      = dss_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dss_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dss_pkg::SIZE_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dss_pkg::CMD_W-1:0]        in_command,
  input  logic                             in_stack_select,
  input  logic signed [dss_pkg::VAL_W-1:0] in_push_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [dss_pkg::VAL_W-1:0] out_read_value,
  output logic [dss_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_first_empty,
  output logic                             out_second_empty,
  output logic                             out_memory_full
);

  dss_pkg::dss_cmd_t cmd;
  dss_pkg::dss_sts_t sts;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dss_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_stack_select  (in_stack_select),
    .in_push_value    (in_push_value),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_first_empty  (out_first_empty),
    .out_second_empty (out_second_empty),
    .out_memory_full  (out_memory_full)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for dual_stack_shared_memory: drives push, pop, peek and
// unused requests under varying shared sizes and handshake pressure, predicts every
// result with a behavioral model of the two stacks and checks each field.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [dss_pkg::VAL_W-1:0] read_value;
  logic [dss_pkg::STATUS_W-1:0]     status;
  logic                             first_empty;
  logic                             second_empty;
  logic                             memory_full;
} stack_result_t;

class stack_result_board;
  localparam int SLOTS = dss_pkg::DEPTH_DEF;

  logic [dss_pkg::VAL_W-1:0]  slots [SLOTS];
  logic [dss_pkg::SIZE_W-1:0] size_reg;
  int unsigned                lower_height;
  int unsigned                upper_height;
  stack_result_t              awaited_results [$];
  int                         errors;

  function new();
    size_reg     = dss_pkg::SIZE_RESET;
    lower_height = 0;
    upper_height = 0;
    errors       = 0;
  endfunction

  function int unsigned shared_size();
    if (size_reg < 2) return 2;
    if (size_reg > SLOTS) return SLOTS;
    return size_reg;
  endfunction

  // a size write empties both stacks
  function void resize(logic [dss_pkg::SIZE_W-1:0] value);
    size_reg     = value;
    lower_height = 0;
    upper_height = 0;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  function void note_request(logic [dss_pkg::CMD_W-1:0] cmd, logic sel,
                             logic [dss_pkg::VAL_W-1:0] val);
    stack_result_t r;
    int unsigned   lim;
    int unsigned   h;
    int unsigned   addr;
    lim = shared_size();
    if (lower_height + upper_height > lim) begin
      lower_height = 0;
      upper_height = 0;
    end
    r = '0;
    r.status = dss_pkg::ST_OK;
    if (cmd == dss_pkg::CMD_PUSH) begin
      if (lower_height + upper_height >= lim) begin
        r.status = dss_pkg::ST_FULL;
      end else if (!sel) begin
        slots[lower_height] = val;
        lower_height++;
      end else begin
        slots[lim - 1 - upper_height] = val;
        upper_height++;
      end
    end else if (cmd == dss_pkg::CMD_POP || cmd == dss_pkg::CMD_PEEK) begin
      h = sel ? upper_height : lower_height;
      if (h == 0) begin
        r.status = dss_pkg::ST_EMPTY;
      end else begin
        addr = sel ? (lim - h) : (h - 1);
        r.read_value = slots[addr];
        if (cmd == dss_pkg::CMD_POP) begin
          if (sel) upper_height--;
          else lower_height--;
        end
      end
    end
    r.first_empty  = (lower_height == 0);
    r.second_empty = (upper_height == 0);
    r.memory_full  = (lower_height + upper_height >= lim);
    awaited_results.push_back(r);
  endfunction

  function void check_result(stack_result_t got);
    stack_result_t want;
    if (awaited_results.size() == 0) begin
      $error("result with no request outstanding: read_value %0h status %0d",
             got.read_value, got.status);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.read_value !== want.read_value) begin
      $error("read_value exp %0h got %0h", want.read_value, got.read_value);
      errors++;
    end
    if (got.status !== want.status) begin
      $error("status exp %0d got %0d", want.status, got.status);
      errors++;
    end
    if (got.first_empty !== want.first_empty) begin
      $error("first_empty exp %0b got %0b", want.first_empty, got.first_empty);
      errors++;
    end
    if (got.second_empty !== want.second_empty) begin
      $error("second_empty exp %0b got %0b", want.second_empty, got.second_empty);
      errors++;
    end
    if (got.memory_full !== want.memory_full) begin
      $error("memory_full exp %0b got %0b", want.memory_full, got.memory_full);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam logic [dss_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASES          = 12;
  localparam int PHASE_REQUESTS  = 90;
  localparam int PRESSURE_PHASE  = 4;
  localparam int PAUSE_PHASE     = 6;

  // sizes beyond the legal range exercise the clamping
  localparam int unsigned PHASE_SIZE [PHASES] =
    '{3, 2047, 1, 16, 1025, 5, 64, 0, 2, 1024, 9, 200};

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [dss_pkg::SIZE_W-1:0]           cfg_wdata;
  logic                                 in_valid;
  logic                                 in_stall;
  logic [dss_pkg::CMD_W-1:0]            in_command;
  logic                                 in_stack_select;
  logic signed [dss_pkg::VAL_W-1:0]     in_push_value;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [dss_pkg::VAL_W-1:0]     out_read_value;
  logic [dss_pkg::STATUS_W-1:0]         out_status;
  logic                                 out_first_empty;
  logic                                 out_second_empty;
  logic                                 out_memory_full;

  stack_result_board sb;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  int cycle_count  = 0;

  dual_stack_shared_memory u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_stack_select  (in_stack_select),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_first_empty  (out_first_empty),
    .out_second_empty (out_second_empty),
    .out_memory_full  (out_memory_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[dual_stack_shared_memory] ERROR");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_read_value, out_status, out_first_empty,
                        out_second_empty, out_memory_full});
    end
  end

  task automatic send_request(input logic [dss_pkg::CMD_W-1:0] cmd, input logic sel,
                              input logic [dss_pkg::VAL_W-1:0] val);
    int gap;
    gap = 0;
    while (tx_idle_pct > 0 && gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_stack_select <= sel;
    in_push_value   <= val;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, sel, val);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [dss_pkg::SIZE_W-1:0] value);
    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.resize(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [dss_pkg::CMD_W-1:0] pick_command(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 70) return dss_pkg::CMD_PUSH;
      if (r < 85) return dss_pkg::CMD_POP;
      if (r < 95) return dss_pkg::CMD_PEEK;
    end else begin
      if (r < 20) return dss_pkg::CMD_PUSH;
      if (r < 70) return dss_pkg::CMD_POP;
      if (r < 95) return dss_pkg::CMD_PEEK;
    end
    return CMD_UNUSED;
  endfunction

  initial begin
    logic [dss_pkg::CMD_W-1:0] cmd;
    bit                        filling;
    int                        trend_left;
    int                        counted;
    int                        issued;

    sb              = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_command      = dss_pkg::CMD_PUSH;
    in_stack_select = 1'b0;
    in_push_value   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty stacks, extreme values, unused command, reset size
    send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
    send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
    send_request(CMD_UNUSED,        1'b0, 32'hFFFF_FFFF);
    send_request(dss_pkg::CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
    send_request(dss_pkg::CMD_PUSH, 1'b0, 32'h8000_0000);
    send_request(dss_pkg::CMD_PUSH, 1'b1, 32'hFFFF_FFFF);
    send_request(dss_pkg::CMD_PUSH, 1'b1, 32'h0000_0000);
    send_request(dss_pkg::CMD_PEEK, 1'b0, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
    send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
    send_request(dss_pkg::CMD_PEEK, 1'b0, 32'h0);
    send_request(CMD_UNUSED,        1'b1, 32'h0);

    // size below the minimum acts as two: fill, refuse, drain
    write_size(11'd0);
    send_request(dss_pkg::CMD_PUSH, 1'b0, 32'h5555_5555);
    send_request(dss_pkg::CMD_PUSH, 1'b1, 32'hAAAA_AAAA);
    send_request(dss_pkg::CMD_PUSH, 1'b0, 32'h1234_5678);
    send_request(dss_pkg::CMD_PUSH, 1'b1, 32'h8765_4321);
    send_request(dss_pkg::CMD_PEEK, 1'b1, 32'h0);
    send_request(CMD_UNUSED,        1'b0, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b0, 32'h0);
    send_request(dss_pkg::CMD_POP,  1'b1, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      write_size(dss_pkg::SIZE_W'(PHASE_SIZE[p]));
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      filling    = 1'b1;
      trend_left = $urandom_range(24, 8);
      counted    = 0;
      issued     = 0;
      while (counted < PHASE_REQUESTS) begin
        if (trend_left == 0) begin
          filling    = !filling;
          trend_left = $urandom_range(24, 8);
        end
        trend_left--;
        // long receiver hold-off so the block backs up into its input
        if (p == PRESSURE_PHASE && issued == 20) hold_req = 1'b1;
        if (p == PAUSE_PHASE && issued == 45) begin
          drop_valid();
          wait_drained();
        end
        cmd = pick_command(filling);
        send_request(cmd, 1'($urandom_range(1, 0)), $urandom);
        issued++;
        if (cmd != CMD_UNUSED) counted++;
      end
    end

    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[dual_stack_shared_memory] OK");
    end else begin
      $display("[dual_stack_shared_memory] ERROR");
    end
    $finish;
  end

endmodule
